>>> rtl/kcv_pkg.sv
`default_nettype none

package kcv_pkg;

   // Character codes used by the canonicalizer and the validity check.
   localparam logic [7:0] CH_A_UP   = 8'h41;
   localparam logic [7:0] CH_Z_UP   = 8'h5A;
   localparam logic [7:0] CH_A_LO   = 8'h61;
   localparam logic [7:0] CH_Z_LO   = 8'h7A;
   localparam logic [7:0] CH_D0     = 8'h30;
   localparam logic [7:0] CH_D9     = 8'h39;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;

   // Limit register reset value and the largest limit that takes effect.
   localparam logic [7:0] LIMIT_RESET = 8'd128;
   localparam logic [7:0] LIMIT_CAP   = 8'd254;
   localparam logic [7:0] COUNT_MAX   = 8'hFF;

   // Status error codes, in priority order.
   localparam logic [2:0] ERR_OK       = 3'd0;
   localparam logic [2:0] ERR_EMPTY    = 3'd1;
   localparam logic [2:0] ERR_TOO_LONG = 3'd2;
   localparam logic [2:0] ERR_BAD_CHAR = 3'd3;
   localparam logic [2:0] ERR_NO_SEP   = 3'd4;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      logic       key_ok;
      logic [2:0] error_code;
      logic [7:0] key_length;
   } rsp_beat_type;

   // Canonicalized byte as delivered from the canonicalizer to the sequencer.
   typedef struct packed {
      logic [7:0] data;
      logic       bad;
      logic       last;
   } canon_type;

endpackage

`default_nettype wire

>>> rtl/kcv_canon.sv
`default_nettype none

module kcv_canon (
   input  wire kcv_pkg::req_beat_type req_data,
   output kcv_pkg::canon_type         canon
);

   logic [7:0] mapped;
   logic       allowed;

   always_comb begin
      mapped = req_data.raw_byte;
      if (mapped >= kcv_pkg::CH_A_UP && mapped <= kcv_pkg::CH_Z_UP) begin
         mapped = mapped | 8'h20;
      end
      if (mapped == kcv_pkg::CH_UNDER || mapped == kcv_pkg::CH_DOT ||
          mapped == kcv_pkg::CH_SPACE || mapped == kcv_pkg::CH_TAB) begin
         mapped = kcv_pkg::CH_HYPHEN;
      end
      allowed = (mapped >= kcv_pkg::CH_A_LO && mapped <= kcv_pkg::CH_Z_LO) ||
                (mapped >= kcv_pkg::CH_D0 && mapped <= kcv_pkg::CH_D9) ||
                mapped == kcv_pkg::CH_HYPHEN || mapped == kcv_pkg::CH_SLASH;
      canon.data = mapped;
      canon.bad  = !allowed;
      canon.last = req_data.last_byte;
   end

endmodule

`default_nettype wire

>>> rtl/kcv_seq.sv
`default_nettype none

module kcv_seq (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire kcv_pkg::canon_type    canon,
   input  wire [7:0]                  limit,
   input  wire                        out_free,
   output logic                       rsp_load,
   output kcv_pkg::rsp_beat_type      rsp_next
);

   // Input stage: one canonical byte and the results of it already sent.
   logic                stg_vld_ff, stg_vld_in;
   kcv_pkg::canon_type  stg_ff, stg_in;
   logic                slash_done_ff, slash_done_in;
   logic                byte_done_ff, byte_done_in;

   // Per-key state.
   logic                pending_ff, pending_in;
   logic                emitted_ff, emitted_in;
   logic [7:0]          count_ff, count_in;
   logic                sep_ff, sep_in;
   logic                bad_ff, bad_in;

   logic                is_slash;
   logic                need_slash;
   logic                need_byte;
   logic                need_status;
   logic                has_res;
   logic                fire;
   logic                done;
   logic                req_acc;
   logic [7:0]          eff_limit;
   logic [7:0]          count_inc;
   logic [2:0]          err;

   always_comb begin
      is_slash    = stg_ff.data == kcv_pkg::CH_SLASH;
      need_slash  = stg_vld_ff && !is_slash && pending_ff && !slash_done_ff;
      need_byte   = stg_vld_ff && !is_slash && !byte_done_ff;
      need_status = stg_vld_ff && stg_ff.last;
      has_res     = need_slash || need_byte || need_status;
      fire        = stg_vld_ff && (!has_res || out_free);
      done        = fire && !need_slash && (!need_byte || !stg_ff.last);
      req_stall   = stg_vld_ff && !done;
      req_acc     = req_valid && !req_stall;
      rsp_load    = fire && has_res;
      count_inc   = (count_ff == kcv_pkg::COUNT_MAX) ? count_ff : count_ff + 8'd1;
      eff_limit   = (limit > kcv_pkg::LIMIT_CAP) ? kcv_pkg::LIMIT_CAP : limit;

      if (count_ff == 8'd0) begin
         err = kcv_pkg::ERR_EMPTY;
      end else if (count_ff > eff_limit) begin
         err = kcv_pkg::ERR_TOO_LONG;
      end else if (bad_ff) begin
         err = kcv_pkg::ERR_BAD_CHAR;
      end else if (!sep_ff) begin
         err = kcv_pkg::ERR_NO_SEP;
      end else begin
         err = kcv_pkg::ERR_OK;
      end

      rsp_next = '0;
      if (need_slash) begin
         rsp_next.out_byte = kcv_pkg::CH_SLASH;
      end else if (need_byte) begin
         rsp_next.out_byte = stg_ff.data;
      end else begin
         rsp_next.is_status  = 1'b1;
         rsp_next.key_ok     = err == kcv_pkg::ERR_OK;
         rsp_next.error_code = err;
         rsp_next.key_length = count_ff;
      end
   end

   // Key state advances one result at a time, so the status sees every
   // byte of the key already counted.
   always_comb begin
      pending_in = pending_ff;
      emitted_in = emitted_ff;
      count_in   = count_ff;
      sep_in     = sep_ff;
      bad_in     = bad_ff;
      if (fire) begin
         if (need_slash) begin
            count_in   = count_inc;
            sep_in     = 1'b1;
            pending_in = 1'b0;
         end else if (need_byte) begin
            count_in   = count_inc;
            emitted_in = 1'b1;
            bad_in     = bad_ff | stg_ff.bad;
         end else if (need_status) begin
            pending_in = 1'b0;
            emitted_in = 1'b0;
            count_in   = '0;
            sep_in     = 1'b0;
            bad_in     = 1'b0;
         end else if (emitted_ff) begin
            pending_in = 1'b1;
         end
      end
   end

   always_comb begin
      stg_vld_in    = stg_vld_ff;
      stg_in        = stg_ff;
      slash_done_in = slash_done_ff;
      byte_done_in  = byte_done_ff;
      if (req_acc) begin
         stg_vld_in    = 1'b1;
         stg_in        = canon;
         slash_done_in = 1'b0;
         byte_done_in  = 1'b0;
      end else if (done) begin
         stg_vld_in = 1'b0;
      end else if (fire) begin
         slash_done_in = slash_done_ff | need_slash;
         byte_done_in  = byte_done_ff | (need_byte && !need_slash);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff    <= 1'b0;
         slash_done_ff <= 1'b0;
         byte_done_ff  <= 1'b0;
         pending_ff    <= 1'b0;
         emitted_ff    <= 1'b0;
         count_ff      <= '0;
         sep_ff        <= 1'b0;
         bad_ff        <= 1'b0;
      end else begin
         stg_vld_ff    <= stg_vld_in;
         slash_done_ff <= slash_done_in;
         byte_done_ff  <= byte_done_in;
         pending_ff    <= pending_in;
         emitted_ff    <= emitted_in;
         count_ff      <= count_in;
         sep_ff        <= sep_in;
         bad_ff        <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
   end

   a_pending_after_byte: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> emitted_ff)
      else $error("slash held before any byte of the key");

   a_sep_after_byte: assert property (@(posedge clock) disable iff (reset)
      sep_ff |-> (emitted_ff && count_ff >= 8'd2))
      else $error("separator recorded without a byte before it");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result loaded into an occupied output register");

   a_status_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_next.is_status) |=>
         (count_ff == 8'd0 && !pending_ff && !emitted_ff && !sep_ff && !bad_ff))
      else $error("key state not cleared after status");

   a_slash_done_stage: assert property (@(posedge clock) disable iff (reset)
      (stg_vld_ff && slash_done_ff) |-> (!is_slash && !pending_ff))
      else $error("held slash sent twice or for a slash byte");

endmodule

`default_nettype wire

>>> rtl/key_canonicalizer_validator.sv
// Key canonicalizer and validator.
// The request channel carries one raw key byte per beat, with last_byte set on
// the final byte of a key. Each byte is canonicalized (upper case to lower
// case; underscore, dot, space and tab to hyphen) and streamed out on the
// response channel. Leading slashes are dropped, runs of slashes collapse to
// one, and a slash is held until a non-slash byte follows, so trailing slashes
// never appear. After the last byte a status beat reports the canonical length
// (saturating at 255) and the validity of the key.
// The limit register is written through csr_wr_en and csr_wr_data, and resets
// to 128; values above 254 act as 254. Write it only while the block is idle.
// A byte is registered in the input stage, its beat in the output register.
// One request beat is taken per cycle while each byte gives one response beat.
// A held slash that goes out ahead of its following byte, and the status beat
// after a last byte that is not a slash, each take a load of their own in the
// single output register; req_stall holds until the byte's last beat loads.
// When the receiver raises rsp_stall, the output register holds its beat and
// the input stage holds its byte; a new request beat can still be accepted in
// the same cycle that the input stage drains.
// Synchronous reset clears the key state, empties both stages and restores the
// limit register; the block takes a request beat as soon as reset is released.
`default_nettype none

module key_canonicalizer_validator (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire kcv_pkg::req_beat_type  req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output kcv_pkg::rsp_beat_type       rsp_data,
   input  wire                         csr_wr_en,
   input  wire [7:0]                   csr_wr_data
);

   kcv_pkg::canon_type     canon;
   kcv_pkg::rsp_beat_type  rsp_next;
   logic                   rsp_load;
   logic                   out_free;

   // Output register: the only place a finished beat waits for the receiver.
   logic                   rsp_valid_ff, rsp_valid_in;
   kcv_pkg::rsp_beat_type  rsp_data_ff, rsp_data_in;

   // Length limit register.
   logic [7:0]             limit_ff, limit_in;

   kcv_canon u_canon (
      .req_data (req_data),
      .canon    (canon)
   );

   kcv_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .canon     (canon),
      .limit     (limit_ff),
      .out_free  (out_free),
      .rsp_load  (rsp_load),
      .rsp_next  (rsp_next)
   );

   // The output register can take a new beat when it is empty or when its
   // current beat is being taken in this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         limit_ff     <= kcv_pkg::LIMIT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> dv/key_canonicalizer_validator_test.sv
module key_canonicalizer_validator_test;

   // Cycles that the receiver holds off in one go, so that both internal
   // stages fill and the block has to raise req_stall.
   localparam int HOLD_CYCLES    = 80;
   // Cycles without any beat on either channel before the run is abandoned.
   // The longest honest quiet stretch is the hold-off above plus a few gaps.
   localparam int STALL_LIMIT    = 2000;
   // A response passes the input stage and the output register after its
   // request is taken; a trailing slash gives no response at all, so this
   // many edges are let pass once the expected beats have all arrived.
   localparam int DRAIN_CYCLES   = 4;
   // Least number of input beats per limit setting in the random part.
   localparam int PHASE_ITEMS    = 8;
   // Long enough to push the canonical count past its saturation point.
   localparam int LONG_KEY_BYTES = 300;

   // One row of the directed script. Where typed is set, the status beat
   // that the row ends with is given by hand in ok, err and len.
   typedef struct packed {
      logic [7:0] raw;
      logic       last;
      logic       typed;
      logic       ok;
      logic [2:0] err;
      logic [7:0] len;
   } script_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   kcv_pkg::req_beat_type req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   kcv_pkg::rsp_beat_type rsp_data;
   logic                  csr_wr_en   = 1'b0;
   logic [7:0]            csr_wr_data = 8'h00;

   // Both handshake sides stop idling while quiet is set. Setting squeeze
   // asks the receiver for one long hold-off.
   bit quiet   = 1'b0;
   bit squeeze = 1'b0;

   int mismatch_count = 0;
   int idle_cycles    = 0;

   // Canonical bytes and status beats that the block still owes us, oldest
   // first.
   kcv_pkg::rsp_beat_type canon_out_q [$];

   // Our own copy of the per-key state and of the limit register.
   logic       held_slash;
   logic       any_out;
   logic [7:0] out_count;
   logic       have_sep;
   logic       have_bad;
   logic [7:0] limit_shadow = kcv_pkg::LIMIT_RESET;

   // The directed part. It starts right after reset, so the limit is the
   // reset value of 128 throughout.
   script_row_type script [0:26] = '{
      // A key made of one slash: the slash leads, so it is dropped and the
      // key is empty.
      '{kcv_pkg::CH_SLASH,  1'b1, 1'b1, 1'b0, kcv_pkg::ERR_EMPTY,    8'd0},
      // Both ends of the upper case range fold down, with a slash between.
      '{kcv_pkg::CH_A_UP,   1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_Z_UP,   1'b1, 1'b1, 1'b1, kcv_pkg::ERR_OK,       8'd3},
      // Every character that turns into a hyphen; no separator at all.
      '{8'h51,              1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_UNDER,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_DOT,    1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SPACE,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_TAB,    1'b1, 1'b1, 1'b0, kcv_pkg::ERR_NO_SEP,   8'd5},
      // The extremes of the byte range pass unchanged and are bad.
      '{8'hFF,              1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{8'h00,              1'b1, 1'b1, 1'b0, kcv_pkg::ERR_BAD_CHAR, 8'd3},
      // A run of slashes collapses, and the trailing slash is trimmed.
      '{kcv_pkg::CH_A_LO,   1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{8'h62,              1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SLASH,  1'b1, 1'b1, 1'b1, kcv_pkg::ERR_OK,       8'd3},
      // Digit extremes and a literal hyphen are all legal.
      '{kcv_pkg::CH_D0,     1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_HYPHEN, 1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_D9,     1'b1, 1'b1, 1'b1, kcv_pkg::ERR_OK,       8'd4},
      // Leading slashes, then the neighbors just outside both letter ranges.
      '{kcv_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{kcv_pkg::CH_SLASH,  1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{8'h40,              1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{8'h5B,              1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{8'h60,              1'b0, 1'b0, 1'b0, kcv_pkg::ERR_OK,       8'd0},
      '{8'h7B,              1'b1, 1'b1, 1'b0, kcv_pkg::ERR_BAD_CHAR, 8'd4}
   };

   key_canonicalizer_validator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Start a new key: everything but the limit goes back to zero.
   function automatic void clear_key_state();
      held_slash = 1'b0;
      any_out    = 1'b0;
      out_count  = 8'd0;
      have_sep   = 1'b0;
      have_bad   = 1'b0;
   endfunction

   // Appends one owed beat at the tail of the queue.
   function automatic void owe_beat(input kcv_pkg::rsp_beat_type beat);
      canon_out_q.insert(canon_out_q.size(), beat);
   endfunction

   // One canonical byte goes out: queue it and count it, with saturation.
   function automatic void emit_canon(input logic [7:0] c);
      kcv_pkg::rsp_beat_type beat;
      beat = '{out_byte: c, is_status: 1'b0, key_ok: 1'b0,
               error_code: kcv_pkg::ERR_OK, key_length: 8'd0};
      owe_beat(beat);
      if (out_count != kcv_pkg::COUNT_MAX) begin
         out_count = out_count + 8'd1;
      end
   endfunction

   // Works out what one accepted input beat makes the block send: a held
   // slash, the canonical byte, and on the last byte the status beat.
   function automatic void canonicalize_byte(input logic [7:0] raw, input logic last);
      logic [7:0]            c;
      logic [7:0]            cap;
      logic [2:0]            err;
      kcv_pkg::rsp_beat_type status;
      c = raw;
      if (c >= kcv_pkg::CH_A_UP && c <= kcv_pkg::CH_Z_UP) begin
         c = c - kcv_pkg::CH_A_UP + kcv_pkg::CH_A_LO;
      end
      if (c == kcv_pkg::CH_UNDER || c == kcv_pkg::CH_DOT || c == kcv_pkg::CH_SPACE ||
          c == kcv_pkg::CH_TAB) begin
         c = kcv_pkg::CH_HYPHEN;
      end
      if (c == kcv_pkg::CH_SLASH) begin
         // A slash is only ever held; before the first byte it is dropped.
         if (any_out) begin
            held_slash = 1'b1;
         end
      end else begin
         if (held_slash) begin
            emit_canon(kcv_pkg::CH_SLASH);
            have_sep   = 1'b1;
            held_slash = 1'b0;
         end
         emit_canon(c);
         any_out = 1'b1;
         if (!((c >= kcv_pkg::CH_A_LO && c <= kcv_pkg::CH_Z_LO) ||
               (c >= kcv_pkg::CH_D0 && c <= kcv_pkg::CH_D9) ||
               c == kcv_pkg::CH_HYPHEN)) begin
            have_bad = 1'b1;
         end
      end
      if (last) begin
         // Limits above the cap act as the cap, so a saturated count of 255
         // can never pass.
         cap = (limit_shadow > kcv_pkg::LIMIT_CAP) ? kcv_pkg::LIMIT_CAP : limit_shadow;
         if (out_count == 8'd0) begin
            err = kcv_pkg::ERR_EMPTY;
         end else if (out_count > cap) begin
            err = kcv_pkg::ERR_TOO_LONG;
         end else if (have_bad) begin
            err = kcv_pkg::ERR_BAD_CHAR;
         end else if (!have_sep) begin
            err = kcv_pkg::ERR_NO_SEP;
         end else begin
            err = kcv_pkg::ERR_OK;
         end
         status = '{out_byte: 8'h00, is_status: 1'b1,
                    key_ok: (err == kcv_pkg::ERR_OK), error_code: err,
                    key_length: out_count};
         owe_beat(status);
         clear_key_state();
      end
   endfunction

   // Offers one input beat, starting at a falling edge and ending at the
   // falling edge after it was taken. Idle gaps come first, with noise on
   // the payload, so that valid is never dropped and raised in one step.
   task automatic send_beat(input logic [7:0] raw, input logic last);
      int gap;
      gap = 0;
      if (!quiet) begin
         while ($urandom_range(0, 99) < 33) begin
            gap++;
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= 9'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{raw_byte: raw, last_byte: last};
      do begin
         @(posedge clock);
      end while (req_stall);
      canonicalize_byte(raw, last);
      @(negedge clock);
   endtask

   // Most key characters are plausible ones: lower and upper case letters,
   // digits, characters that map to a hyphen, and slashes. Noisy keys, and
   // a few characters of every key, take any byte at all.
   function automatic logic [7:0] key_char(input bit noisy);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (noisy || roll < 8) begin
         return 8'($urandom_range(0, 255));
      end else if (roll < 55) begin
         return 8'($urandom_range(kcv_pkg::CH_A_LO, kcv_pkg::CH_Z_LO));
      end else if (roll < 65) begin
         return 8'($urandom_range(kcv_pkg::CH_A_UP, kcv_pkg::CH_Z_UP));
      end else if (roll < 77) begin
         return 8'($urandom_range(kcv_pkg::CH_D0, kcv_pkg::CH_D9));
      end else if (roll < 87) begin
         case ($urandom_range(0, 4))
            0: return kcv_pkg::CH_UNDER;
            1: return kcv_pkg::CH_DOT;
            2: return kcv_pkg::CH_SPACE;
            3: return kcv_pkg::CH_TAB;
            default: return kcv_pkg::CH_HYPHEN;
         endcase
      end
      return kcv_pkg::CH_SLASH;
   endfunction

   task automatic send_key(input int len, input bit noisy);
      for (int i = 0; i < len; i++) begin
         send_beat(key_char(noisy), i == len - 1);
      end
   endtask

   // Brings the block to idle: stop offering, wait for every owed beat,
   // then give a trailing slash time to work through. Ends on a falling edge.
   task automatic settle();
      req_valid <= 1'b0;
      while (canon_out_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // The receiver. It stalls in about a third of all cycles while quiet is
   // clear, and holds off for one long stretch each time squeeze is set.
   initial begin
      forever begin
         @(negedge clock);
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 33);
         end
      end
   end

   // Every response beat taken is held against the oldest owed one.
   always @(posedge clock) begin
      kcv_pkg::rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (canon_out_q.size() == 0) begin
            $error("response beat %h with nothing owed", rsp_data);
            mismatch_count++;
         end else begin
            want = canon_out_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               mismatch_count++;
            end
            if (rsp_data.is_status !== want.is_status) begin
               $error("is_status: expected %b, got %b", want.is_status, rsp_data.is_status);
               mismatch_count++;
            end
            if (rsp_data.key_ok !== want.key_ok) begin
               $error("key_ok: expected %b, got %b", want.key_ok, rsp_data.key_ok);
               mismatch_count++;
            end
            if (rsp_data.error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code,
                      rsp_data.error_code);
               mismatch_count++;
            end
            if (rsp_data.key_length !== want.key_length) begin
               $error("key_length: expected %0d, got %0d", want.key_length,
                      rsp_data.key_length);
               mismatch_count++;
            end
         end
      end
   end

   // A hung handshake ends the run instead of letting it spin forever.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0]            limits [7];
      kcv_pkg::rsp_beat_type typed;
      int                    sent;
      int                    len;
      int unsigned           roll;

      clear_key_state();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Rows with a hand-typed status replace the predicted
      // one at the tail of the queue.
      foreach (script[i]) begin
         send_beat(script[i].raw, script[i].last);
         if (script[i].typed) begin
            typed = '{out_byte: 8'h00, is_status: 1'b1, key_ok: script[i].ok,
                      error_code: script[i].err, key_length: script[i].len};
            canon_out_q[$] = typed;
         end
      end

      // Random part, one phase per limit. The list covers the legal ends,
      // zero, a value above the cap, a tight limit that long keys exceed,
      // a random one, and finally the reset value again.
      limits = '{8'd1, 8'd0, 8'd255, kcv_pkg::LIMIT_CAP, 8'd3,
                 8'($urandom_range(1, 254)), kcv_pkg::LIMIT_RESET};
      foreach (limits[p]) begin
         settle();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= limits[p];
         @(posedge clock);
         limit_shadow = limits[p];
         @(negedge clock);
         csr_wr_en   <= 1'b0;
         csr_wr_data <= 8'($urandom);

         // Above the cap, one long key streams with no idling on either side
         // so the count saturates; the receiver holds off near its start
         // while the sender keeps offering, and both stages fill up.
         if (limits[p] > kcv_pkg::LIMIT_CAP) begin
            quiet   = 1'b1;
            squeeze = 1'b1;
            send_key(LONG_KEY_BYTES, 1'b0);
            quiet   = 1'b0;
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               // Nothing but slashes: an empty key.
               len = $urandom_range(1, 3);
               for (int i = 0; i < len; i++) begin
                  send_beat(kcv_pkg::CH_SLASH, i == len - 1);
               end
            end else begin
               len = $urandom_range(1, 12);
               send_key(len, roll >= 80);
            end
            sent += len;
         end
      end

      settle();
      if (mismatch_count == 0 && canon_out_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/kcv_pkg.sv
rtl/kcv_canon.sv
rtl/kcv_seq.sv
rtl/key_canonicalizer_validator.sv
dv/key_canonicalizer_validator_test.sv
